>>> hdl/maf_pkg.sv
// ----------------------------------------------------------------------------
// maf_pkg
// shared constants, types and the bucket hash for the mac acl frame filter
// ----------------------------------------------------------------------------
package maf_pkg;

	localparam int unsigned BUCKETS_DEF = 16;
	localparam int unsigned WAYS_DEF    = 4;

	localparam logic [1:0] CMD_INSERT   = 2'd0;
	localparam logic [1:0] CMD_CLASSIFY = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	localparam logic [2:0] REG_FILTER_EN = 3'd0;
	localparam logic [2:0] REG_BLOCK     = 3'd1;
	localparam logic [2:0] REG_LOCAL_IP  = 3'd2;
	localparam logic [2:0] REG_LOCAL_MSK = 3'd3;
	localparam logic [2:0] REG_LOCAL_VLD = 3'd4;
	localparam logic [2:0] REG_DNS_REP   = 3'd5;

	localparam logic [31:0] FIXED_IP  = 32'h0101_0102;
	localparam logic [15:0] ET_IP     = 16'h0800;
	localparam logic [15:0] ET_ARP    = 16'h0806;
	localparam logic [15:0] ET_EAPOL  = 16'h888e;
	localparam logic [15:0] ET_HYD    = 16'h893a;
	localparam logic [7:0]  PROTO_TCP = 8'd6;
	localparam logic [7:0]  PROTO_UDP = 8'd17;
	localparam logic [15:0] PORT_DHCP_S = 16'd67;
	localparam logic [15:0] PORT_DHCP_C = 16'd68;
	localparam logic [15:0] PORT_DNS    = 16'd53;
	localparam logic [15:0] PORT_HTTP   = 16'd80;
	localparam logic [15:0] PORT_HTTPS  = 16'd443;

	typedef struct packed {
		logic       filter_enabled;
		logic       block_mode;
		logic [31:0] local_ip;
		logic [31:0] local_mask;
		logic       local_ip_valid;
		logic       dns_report_enabled;
	} maf_cfg_t;

	function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
		rotl = (x << k) | (x >> (32 - k));
	endfunction

	// lookup3 over six bytes, initval 0: key load and the first three mix steps
	// the key bytes do not overlap, so each load is a single add
	function automatic logic [95:0] mac_hash_front(input logic [47:0] mac);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = 32'hdeadbef5 + {mac[23:16], mac[31:24], mac[39:32], mac[47:40]};
		b = 32'hdeadbef5 + {16'd0, mac[7:0], mac[15:8]};
		c = 32'hdeadbef5;
		c = c ^ b; c = c - rotl(b, 14);
		a = a ^ c; a = a - rotl(c, 11);
		b = b ^ a; b = b - rotl(a, 25);
		mac_hash_front = {a, b, c};
	endfunction

	// remaining four mix steps, returns the final c word
	function automatic logic [31:0] mac_hash_back(input logic [95:0] abc);
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		a = abc[95:64];
		b = abc[63:32];
		c = abc[31:0];
		c = c ^ b; c = c - rotl(b, 16);
		a = a ^ c; a = a - rotl(c, 4);
		b = b ^ a; b = b - rotl(a, 14);
		c = c ^ b; c = c - rotl(b, 24);
		mac_hash_back = c;
	endfunction

endpackage

>>> hdl/maf_table.sv
// ----------------------------------------------------------------------------
// maf_table
// bucketed mac store: one bucket row per address, all ways in one word
// ----------------------------------------------------------------------------
module maf_table import maf_pkg::*; #(
	parameter int unsigned BUCKETS = BUCKETS_DEF,
	parameter int unsigned WAYS    = WAYS_DEF,
	localparam int unsigned BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
	localparam int unsigned WW     = (WAYS > 1) ? $clog2(WAYS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [BW-1:0]       rd_addr,
	output logic [WAYS*48-1:0]  rd_data,
	output logic [WAYS-1:0]     rd_valid,
	input  logic                wr_en,
	input  logic [BW-1:0]       wr_addr,
	input  logic [WW-1:0]       wr_way,
	input  logic [47:0]         wr_mac,
	input  logic                clear
);

	logic [WAYS*48-1:0] mem [BUCKETS];
	logic [WAYS-1:0] vld_q [BUCKETS];
	logic [WAYS-1:0] vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr][32'(wr_way) * 48 +: 48] <= wr_mac;
		end
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUCKETS; i++) vld_q[i] <= '0;
			vld_rd_q <= '0;
		end else begin
			vld_rd_q <= vld_q[rd_addr];
			if (clear) begin
				for (int i = 0; i < BUCKETS; i++) vld_q[i] <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr][wr_way] <= 1'b1;
			end
		end
	end

	assign rd_valid = vld_rd_q;

endmodule

>>> hdl/maf_cfg_regs.sv
// ----------------------------------------------------------------------------
// maf_cfg_regs
// configuration register file
// ----------------------------------------------------------------------------
module maf_cfg_regs import maf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output maf_cfg_t    cfg
);

	maf_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_FILTER_EN: cfg_q.filter_enabled <= cfg_data[0];
				REG_BLOCK:     cfg_q.block_mode <= cfg_data[0];
				REG_LOCAL_IP:  cfg_q.local_ip <= cfg_data;
				REG_LOCAL_MSK: cfg_q.local_mask <= cfg_data;
				REG_LOCAL_VLD: cfg_q.local_ip_valid <= cfg_data[0];
				REG_DNS_REP:   cfg_q.dns_report_enabled <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/mac_acl_frame_filter_top.sv
// ----------------------------------------------------------------------------
// mac_acl_frame_filter_top
// mac address access list with per-frame pass/drop classification
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_stall) carries one command per transaction:
//   insert an address, classify a frame, or clear the table. each command
//   gives exactly one result on the output channel (out_valid/out_stall).
//   configuration writes use cfg_valid/cfg_ready (always ready) and are
//   made while the block is idle.
//   flow: one command at a time. the bucket hash is split over the S_HA
//   and S_HB states, then the bucket row is read (S_RD) and compared
//   (S_CMP). insert gives its result from S_CMP; classify with lookups
//   reads the source bucket and then the destination bucket (S_DHA,
//   S_DHB, S_DRD, S_DONE); an exempt classify, clear and an unknown
//   command give their result from S_HA.
//   the result waits in the output register while out_stall is high;
//   the next command is taken once the result register has been emptied.
//   reset clears the valid bits of the table, the registers and the
//   control; table contents are only read behind a set valid bit.
// ----------------------------------------------------------------------------
module mac_acl_frame_filter_top import maf_pkg::*; #(
	parameter int unsigned BUCKETS = BUCKETS_DEF,
	parameter int unsigned WAYS    = WAYS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [47:0] entry_mac,
	input  logic [47:0] src_mac,
	input  logic [47:0] dst_mac,
	input  logic [15:0] ethertype,
	input  logic [7:0]  ip_proto,
	input  logic [31:0] ip_src,
	input  logic [31:0] ip_dst,
	input  logic [15:0] l4_src_port,
	input  logic [15:0] l4_dst_port,
	input  logic [1:0]  check_mask,
	input  logic        from_backhaul,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        pass,
	output logic [1:0]  status,
	output logic        report_to_host,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int unsigned WW = (WAYS > 1) ? $clog2(WAYS) : 1;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_HA   = 9'b000000010,
		S_HB   = 9'b000000100,
		S_RD   = 9'b000001000,
		S_CMP  = 9'b000010000,
		S_DHA  = 9'b000100000,
		S_DHB  = 9'b001000000,
		S_DRD  = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;
	maf_cfg_t cfg;

	logic [1:0]  cmd_q;
	logic [47:0] mac_q, dst_q;
	logic        early_pass_q, chk_src_q, chk_dst_q, src_hit_q;
	logic        udp_q, dns_q_q, web_q, dns_rep_q;
	logic [95:0] mix_q;
	logic [BW-1:0] bkt_q;

	logic [WAYS*48-1:0] rd_data;
	logic [WAYS-1:0]    rd_valid;
	logic               hit;
	logic               free_any;
	logic [WW-1:0]      free_way;
	logic               mac_ok;
	logic               wr_en, clear;

	logic       res_pass, out_valid_q, pass_q, rep_q;
	logic [1:0] status_q;

	maf_cfg_regs u_cfg (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .cfg
	);

	maf_table #(.BUCKETS(BUCKETS), .WAYS(WAYS)) u_tbl (
		.clk, .arst_n,
		.rd_addr (bkt_q),
		.rd_data,
		.rd_valid,
		.wr_en,
		.wr_addr (bkt_q),
		.wr_way  (free_way),
		.wr_mac  (mac_q),
		.clear
	);

	always_comb begin
		hit = 1'b0;
		free_any = 1'b0;
		free_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (rd_valid[w] && rd_data[w*48 +: 48] == mac_q) hit = 1'b1;
			if (!rd_valid[w]) begin
				free_any = 1'b1;
				free_way = WW'(w);
			end
		end
	end

	logic accept;
	assign in_stall = !(state_q == S_IDLE) || out_valid_q;
	assign accept   = in_valid && !in_stall;

	// frame pre-decode done at accept
	logic is_ip, tcp, udp, dnsq, early, subnet, web;
	always_comb begin
		is_ip  = ethertype == ET_IP;
		tcp    = is_ip && ip_proto == PROTO_TCP;
		udp    = is_ip && ip_proto == PROTO_UDP;
		dnsq   = udp && l4_dst_port == PORT_DNS && cfg.dns_report_enabled;
		subnet = cfg.local_ip_valid && ((ip_dst ^ cfg.local_ip) & cfg.local_mask) == '0;
		early  = !cfg.filter_enabled || ethertype == ET_ARP || ethertype == ET_EAPOL
			|| (is_ip && (ip_src == FIXED_IP || ip_dst == FIXED_IP))
			|| (udp && (l4_dst_port == PORT_DHCP_S || l4_dst_port == PORT_DHCP_C))
			|| ethertype == ET_HYD
			|| (from_backhaul && !dnsq && (!tcp || subnet));
		web    = tcp && (l4_dst_port == PORT_HTTP || l4_src_port == PORT_HTTP
			|| l4_dst_port == PORT_HTTPS || l4_src_port == PORT_HTTPS)
			&& cfg.local_ip_valid
			&& (cfg.local_ip == ip_src || cfg.local_ip == ip_dst || subnet);
	end

	// multicast and all-zero addresses never go into the table
	assign mac_ok = mac_q != '0 && !mac_q[40];
	assign wr_en = state_q == S_CMP && cmd_q == CMD_INSERT && mac_ok && !hit && free_any;
	assign clear = state_q == S_HA && cmd_q == CMD_CLEAR;

	// final verdict for classify, dst hit comes from the current read
	logic dst_hit, drop;
	always_comb begin
		dst_hit = state_q == S_DONE && chk_dst_q && hit;
		if (cfg.block_mode) drop = src_hit_q || dst_hit;
		else drop = (chk_src_q && !src_hit_q) || (chk_dst_q && !dst_hit);
		res_pass = !drop || web_q || (udp_q && dns_rep_q);
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q  <= cmd;
			mac_q  <= (cmd == CMD_INSERT) ? entry_mac : src_mac;
			dst_q  <= dst_mac;
			early_pass_q <= early;
			chk_src_q <= check_mask[0];
			chk_dst_q <= check_mask[1] && !dst_mac[40];
			udp_q  <= udp;
			dns_q_q <= dnsq;
			web_q  <= web;
			dns_rep_q <= l4_src_port == PORT_DNS;
		end
		if (state_q == S_HA || state_q == S_DHA) mix_q <= mac_hash_front(mac_q);
		if (state_q == S_HB || state_q == S_DHB) begin
			bkt_q <= BW'(mac_hash_back(mix_q) % BUCKETS);
		end
		// source compare done, switch the key to the destination address
		if (state_q == S_CMP && cmd_q == CMD_CLASSIFY) begin
			src_hit_q <= chk_src_q && hit;
			mac_q <= dst_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			pass_q <= 1'b0;
			status_q <= ST_OK;
			rep_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_HA;
				S_HA: begin
					if (cmd_q == CMD_INSERT || (cmd_q == CMD_CLASSIFY && !early_pass_q)) begin
						state_q <= S_HB;
					end else begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						pass_q <= cmd_q == CMD_CLASSIFY;
						status_q <= ST_OK;
						rep_q <= 1'b0;
					end
				end
				S_HB:  state_q <= S_RD;
				S_RD:  state_q <= S_CMP;
				S_CMP: begin
					if (cmd_q == CMD_INSERT) begin
						state_q <= S_IDLE;
						out_valid_q <= 1'b1;
						pass_q <= 1'b0;
						rep_q <= 1'b0;
						if (!mac_ok) status_q <= ST_INVALID;
						else if (hit || free_any) status_q <= ST_OK;
						else status_q <= ST_FULL;
					end else begin
						state_q <= S_DHA;
					end
				end
				S_DHA: state_q <= S_DHB;
				S_DHB: state_q <= S_DRD;
				S_DRD: state_q <= S_DONE;
				S_DONE: begin
					state_q <= S_IDLE;
					out_valid_q <= 1'b1;
					pass_q <= res_pass;
					status_q <= ST_OK;
					rep_q <= !res_pass && dns_q_q;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign pass = pass_q;
	assign status = status_q;
	assign report_to_host = rep_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> in_stall) else $error("accept while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result lost");
	a_wr_only_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> state_q == S_CMP && !hit) else $error("bad write");
	a_rep_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && report_to_host |-> !pass) else $error("report on pass");

endmodule

>>> bench/mac_acl_frame_filter_top_test.sv
// ----------------------------------------------------------------------------
// mac_acl_frame_filter_top_test
// drives insert, classify, clear and unknown commands into the mac acl frame
// filter, predicts every result from a model of the hashed address table and
// the frame rules, and checks each whole result in order
// ----------------------------------------------------------------------------
module mac_acl_frame_filter_top_test;
	import maf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB = BUCKETS_DEF;
	localparam int NW = WAYS_DEF;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [47:0] entry_mac;
		logic [47:0] src_mac;
		logic [47:0] dst_mac;
		logic [15:0] ethertype;
		logic [7:0]  ip_proto;
		logic [31:0] ip_src;
		logic [31:0] ip_dst;
		logic [15:0] l4_src_port;
		logic [15:0] l4_dst_port;
		logic [1:0]  check_mask;
		logic        from_backhaul;
	} frame_cmd_t;

	typedef struct packed {
		logic       pass;
		logic [1:0] status;
		logic       report_to_host;
	} verdict_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	frame_cmd_t cur = '0;
	logic out_valid;
	logic out_stall = 0;
	logic pass;
	logic [1:0] status;
	logic report_to_host;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	frame_cmd_t pending_cmds[$];
	verdict_t expected_verdicts[$];
	int mismatches = 0;
	bit hold_rx = 0;

	// model of table and registers
	logic [47:0] tbl_mac[NB*NW];
	bit tbl_vld[NB*NW];
	maf_cfg_t regs = '0;
	logic [47:0] known_macs[$];

	mac_acl_frame_filter_top i_dut (
		.clk, .arst_n, .in_valid, .in_stall,
		.cmd(cur.cmd), .entry_mac(cur.entry_mac), .src_mac(cur.src_mac),
		.dst_mac(cur.dst_mac), .ethertype(cur.ethertype), .ip_proto(cur.ip_proto),
		.ip_src(cur.ip_src), .ip_dst(cur.ip_dst), .l4_src_port(cur.l4_src_port),
		.l4_dst_port(cur.l4_dst_port), .check_mask(cur.check_mask),
		.from_backhaul(cur.from_backhaul),
		.out_valid, .out_stall, .pass, .status, .report_to_host,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] rol32(logic [31:0] x, int k);
		return (x << k) | (x >> (32 - k));
	endfunction

	function automatic int bucket_index(logic [47:0] m);
		logic [31:0] a, b, c;
		a = 32'hdeadbeef + 6;
		b = a;
		c = a;
		b += {24'd0, m[7:0]} << 8;
		b += {24'd0, m[15:8]};
		a += {24'd0, m[23:16]} << 24;
		a += {24'd0, m[31:24]} << 16;
		a += {24'd0, m[39:32]} << 8;
		a += {24'd0, m[47:40]};
		c ^= b; c -= rol32(b, 14);
		a ^= c; a -= rol32(c, 11);
		b ^= a; b -= rol32(a, 25);
		c ^= b; c -= rol32(b, 16);
		a ^= c; a -= rol32(c, 4);
		b ^= a; b -= rol32(a, 14);
		c ^= b; c -= rol32(b, 24);
		return int'(c % NB);
	endfunction

	function automatic bit table_hit(logic [47:0] m);
		int base;
		base = bucket_index(m) * NW;
		for (int w = 0; w < NW; w++)
			if (tbl_vld[base+w] && tbl_mac[base+w] == m) return 1;
		return 0;
	endfunction

	function automatic bit in_subnet(logic [31:0] ip);
		return regs.local_ip_valid && ((ip ^ regs.local_ip) & regs.local_mask) == 0;
	endfunction

	function automatic verdict_t predict_verdict(frame_cmd_t f);
		verdict_t v;
		int base;
		bit is_ip, tcp, udp, dns_q, sh, dh, sok, dok, drop, done;
		v = '0;
		case (f.cmd)
			CMD_INSERT: begin
				if (f.entry_mac == 0 || f.entry_mac[40]) v.status = ST_INVALID;
				else if (!table_hit(f.entry_mac)) begin
					base = bucket_index(f.entry_mac) * NW;
					v.status = ST_FULL;
					for (int w = 0; w < NW; w++)
						if (v.status == ST_FULL && !tbl_vld[base+w]) begin
							tbl_vld[base+w] = 1;
							tbl_mac[base+w] = f.entry_mac;
							v.status = ST_OK;
						end
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < NB*NW; i++) tbl_vld[i] = 0;
			end
			CMD_CLASSIFY: begin
				is_ip = f.ethertype == ET_IP;
				tcp = is_ip && f.ip_proto == PROTO_TCP;
				udp = is_ip && f.ip_proto == PROTO_UDP;
				dns_q = udp && f.l4_dst_port == PORT_DNS && regs.dns_report_enabled;
				v.pass = 1;
				done = 1;
				if (!regs.filter_enabled) ;
				else if (f.ethertype == ET_ARP || f.ethertype == ET_EAPOL) ;
				else if (is_ip && (f.ip_src == FIXED_IP || f.ip_dst == FIXED_IP)) ;
				else if (udp && (f.l4_dst_port == PORT_DHCP_S
						|| f.l4_dst_port == PORT_DHCP_C)) ;
				else if (f.ethertype == ET_HYD) ;
				else if (f.from_backhaul && !dns_q && (!tcp || in_subnet(f.ip_dst))) ;
				else done = 0;
				if (!done) begin
					sh = 0; dh = 0; sok = 1; dok = 1;
					if (f.check_mask[0]) begin
						sh = table_hit(f.src_mac);
						sok = sh;
					end
					if (f.check_mask[1] && !f.dst_mac[40]) begin
						dh = table_hit(f.dst_mac);
						dok = dh;
					end
					drop = regs.block_mode ? (sh || dh) : (!sok || !dok);
					if (drop) begin
						if (tcp && (f.l4_dst_port == PORT_HTTP || f.l4_src_port == PORT_HTTP
								|| f.l4_dst_port == PORT_HTTPS || f.l4_src_port == PORT_HTTPS)
								&& regs.local_ip_valid && (regs.local_ip == f.ip_src
								|| regs.local_ip == f.ip_dst || in_subnet(f.ip_dst))) ;
						else if (udp && f.l4_src_port == PORT_DNS) ;
						else begin
							v.pass = 0;
							v.report_to_host = dns_q;
						end
					end
				end
			end
			default: ;
		endcase
		return v;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (!in_valid || !in_stall) begin
				if (in_valid) expected_verdicts.push_back(predict_verdict(cur));
				if (pending_cmds.size() > 0 && ($urandom_range(0, 3) != 0)) begin
					cur <= pending_cmds.pop_front();
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver stall: mostly short gaps, a few long ones
	int stall_left = 0;
	always @(posedge clk) begin
		if (hold_rx) out_stall <= 1;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
				: $urandom_range(0, 3);
			out_stall <= 1;
		end else out_stall <= 0;
	end

	// monitor
	always @(posedge clk) begin
		verdict_t got, exp_v;
		if (arst_n && out_valid && !out_stall) begin
			got = '{pass, status, report_to_host};
			if (expected_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %p", got);
			end else begin
				exp_v = expected_verdicts.pop_front();
				if (got !== exp_v) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_v, got);
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			REG_FILTER_EN: regs.filter_enabled = val[0];
			REG_BLOCK:     regs.block_mode = val[0];
			REG_LOCAL_IP:  regs.local_ip = val;
			REG_LOCAL_MSK: regs.local_mask = val;
			REG_LOCAL_VLD: regs.local_ip_valid = val[0];
			REG_DNS_REP:   regs.dns_report_enabled = val[0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_cmds.size() > 0 || in_valid || expected_verdicts.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [47:0] rand_mac();
		return 48'({$urandom, $urandom});
	endfunction

	function automatic logic [47:0] pick_mac();
		int r;
		r = $urandom_range(0, 9);
		if (known_macs.size() > 0 && r < 6)
			return known_macs[$urandom_range(0, known_macs.size() - 1)];
		if (r == 6) return rand_mac() | 48'h0100_0000_0000;
		return rand_mac();
	endfunction

	function automatic frame_cmd_t rand_frame();
		frame_cmd_t f;
		logic [319:0] rnd;
		int r;
		rnd = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom};
		f = rnd[$bits(frame_cmd_t)-1:0];
		f.cmd = CMD_CLASSIFY;
		f.src_mac = pick_mac();
		f.dst_mac = pick_mac();
		r = $urandom_range(0, 19);
		if (r < 14) f.ethertype = ET_IP;
		else if (r == 14) f.ethertype = ET_ARP;
		else if (r == 15) f.ethertype = ET_EAPOL;
		else if (r == 16) f.ethertype = ET_HYD;
		r = $urandom_range(0, 9);
		if (r < 4) f.ip_proto = PROTO_TCP;
		else if (r < 8) f.ip_proto = PROTO_UDP;
		if ($urandom_range(0, 1)) begin
			case ($urandom_range(0, 4))
				0: f.l4_dst_port = PORT_DNS;
				1: f.l4_src_port = PORT_DNS;
				2: f.l4_dst_port = $urandom_range(0, 1) ? PORT_HTTP : PORT_HTTPS;
				3: f.l4_src_port = $urandom_range(0, 1) ? PORT_HTTP : PORT_HTTPS;
				default: f.l4_dst_port = $urandom_range(0, 1) ? PORT_DHCP_S : PORT_DHCP_C;
			endcase
		end
		r = $urandom_range(0, 19);
		if (r == 0) f.ip_src = FIXED_IP;
		else if (r == 1) f.ip_dst = FIXED_IP;
		else if (r < 8) f.ip_dst = regs.local_ip ^ ($urandom & ~regs.local_mask);
		else if (r < 11) f.ip_src = regs.local_ip;
		else if (r < 13) f.ip_dst = regs.local_ip;
		f.from_backhaul = ($urandom_range(0, 3) == 0);
		return f;
	endfunction

	task automatic add_random(int n);
		frame_cmd_t f;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			f = rand_frame();
			if (r < 25) begin
				f.cmd = CMD_INSERT;
				f.entry_mac = ($urandom_range(0, 4) == 0) ? pick_mac() : rand_mac();
				if ($urandom_range(0, 9) == 0) f.entry_mac = '0;
				if (!f.entry_mac[40] && f.entry_mac != 0) known_macs.push_back(f.entry_mac);
			end else if (r < 27) begin
				f.cmd = CMD_CLEAR;
			end else if (r < 29) begin
				f.cmd = CMD_UNKNOWN;
			end
			pending_cmds.push_back(f);
		end
	endtask

	initial begin
		frame_cmd_t f;
		for (int i = 0; i < NB*NW; i++) begin
			tbl_vld[i] = 0;
			tbl_mac[i] = '0;
		end
		repeat (10) @(posedge clk);
		arst_n <= 1;
		repeat (2) @(posedge clk);

		// directed: reset registers pass everything, then fill one bucket past full
		f = '0;
		f.cmd = CMD_CLASSIFY;
		f.src_mac = '1; f.dst_mac = '1; f.check_mask = 2'b11;
		pending_cmds.push_back(f);
		f = '0; f.cmd = CMD_INSERT; f.entry_mac = '0; pending_cmds.push_back(f);
		f.entry_mac = 48'h0100_0000_0001; pending_cmds.push_back(f);
		f.entry_mac = 48'hfeff_ffff_ffff; pending_cmds.push_back(f);
		f.entry_mac = 48'hfeff_ffff_ffff; pending_cmds.push_back(f);
		f.entry_mac = 48'h0000_0000_0001; pending_cmds.push_back(f);
		f = '1; f.cmd = CMD_UNKNOWN; pending_cmds.push_back(f);
		wait_idle();
		begin
			int tgt, cnt;
			logic [47:0] m;
			tgt = bucket_index(48'h0200_0000_0000);
			cnt = 0;
			while (cnt < NW + 1) begin
				m = rand_mac() & 48'hfeff_ffff_ffff;
				if (m != 0 && bucket_index(m) == tgt) begin
					f = '0; f.cmd = CMD_INSERT; f.entry_mac = m;
					pending_cmds.push_back(f);
					known_macs.push_back(m);
					cnt++;
				end
			end
		end
		wait_idle();
		write_reg(REG_FILTER_EN, 32'd1);
		write_reg(REG_LOCAL_IP, 32'hc0a8_0101);
		write_reg(REG_LOCAL_MSK, 32'hffff_ff00);
		write_reg(REG_LOCAL_VLD, 32'd1);
		write_reg(REG_DNS_REP, 32'd1);
		write_reg(REG_BLOCK, 32'd0);
		for (int i = 0; i < 10; i++) pending_cmds.push_back(rand_frame());
		f = '0; f.cmd = CMD_CLEAR; pending_cmds.push_back(f);
		f = '1; f.cmd = CMD_CLASSIFY; f.ethertype = ET_IP; pending_cmds.push_back(f);
		wait_idle();

		// random phases across register settings
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_FILTER_EN, (ph == 7) ? 32'd0 : 32'd1);
			write_reg(REG_BLOCK, 32'(ph[0]));
			write_reg(REG_LOCAL_IP, (ph == 2) ? 32'hffff_ffff : (ph == 3) ? 32'd0 : $urandom);
			write_reg(REG_LOCAL_MSK, (ph == 4) ? 32'd0 : (ph == 5) ? 32'hffff_ffff
				: 32'hffff_ff00);
			write_reg(REG_LOCAL_VLD, 32'(ph != 6));
			write_reg(REG_DNS_REP, 32'(ph[1]));
			if (ph == 3) hold_rx = 1;
			add_random(100);
			if (ph == 3) begin
				repeat (300) @(posedge clk);
				hold_rx = 0;
			end
			wait_idle();
		end

		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_verdicts.size() == 0)
			$display("mac_acl_frame_filter_top_test: clean");
		else
			$display("mac_acl_frame_filter_top_test: errors");
		$finish;
	end

	initial begin
		#20ms;
		$display("mac_acl_frame_filter_top_test: errors");
		$finish;
	end

endmodule
